[design/pjg_pkg.sv]
// shared widths and register codes for the jacobi grid solver
package pjg_pkg;

    localparam int VAL_W  = 48;   // cell value, signed q31.16
    localparam int CFG_W  = 16;   // configuration register width
    localparam int POS_W  = 3;    // row / col field width
    localparam int H2_W   = 24;   // h^2 in q.16
    localparam int H2X_W  = 28;   // 10 * h^2
    localparam int S_W    = 7;    // i^2 + j^2
    localparam int A_W    = 32;   // x^2 + y^2 + 10 in q.16
    localparam int T_W    = 44;   // source term in q.16
    localparam int ACC_W  = 50;   // sum of four neighbors
    localparam int SUM_W  = 51;   // neighbors plus source term

    localparam logic [A_W-1:0] TEN_Q16 = A_W'(10 << 16);

    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_ITERATION_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_SPACING    = 2'd1;

endpackage

[design/pjg_ram.sv]
// one write port, one registered read port memory
module pjg_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 48
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/pjg_src.sv]
// source term pipeline: h^2 at solve start, then per cell term in two stages
module pjg_src (
    input  logic                          clk,
    input  logic                          prep,
    input  logic [pjg_pkg::CFG_W-1:0]     spacing,
    input  logic [pjg_pkg::POS_W-1:0]     row,
    input  logic [pjg_pkg::POS_W-1:0]     col,
    output logic [pjg_pkg::T_W-1:0]       term
);

    logic [pjg_pkg::H2_W-1:0]  h2_reg;
    logic [pjg_pkg::H2X_W-1:0] h2x10_reg;
    logic [pjg_pkg::A_W-1:0]   a_reg;
    logic [pjg_pkg::T_W-1:0]   t_reg;
    logic [31:0]               hh;
    logic [pjg_pkg::S_W-1:0]   s;
    logic [59:0]               prod;

    assign hh   = 32'(spacing) * 32'(spacing);
    assign s    = pjg_pkg::S_W'(row) * pjg_pkg::S_W'(row)
                + pjg_pkg::S_W'(col) * pjg_pkg::S_W'(col);
    assign prod = 60'(h2x10_reg) * 60'(a_reg);

    always_ff @(posedge clk)
    begin
        if (prep)
        begin
            h2_reg <= hh[31:8];
        end
        h2x10_reg <= pjg_pkg::H2X_W'(h2_reg) * pjg_pkg::H2X_W'(10);
        a_reg     <= pjg_pkg::A_W'(h2_reg) * pjg_pkg::A_W'(s) + pjg_pkg::TEN_Q16;
        t_reg     <= prod[59:16];
    end

    assign term = t_reg;

endmodule

[design/poisson_jacobi_grid_solver_unit.sv]
// top level of the five-point jacobi poisson grid solver
// usage
//   s_* channel: one grid cell per beat, row-major, tdata = signed q31.16 value,
//   tlast marks the final cell and starts the solve. cells load one per cycle.
//   m_* channel: after the solve, all GRID*GRID cells leave row-major with row
//   and col beside the value; tlast marks the final cell.
//   cfg_* port: register 0 is the sweep count, register 1 the spacing h (q4.12).
//   write it only while the block is idle.
// timing
//   a sweep makes three passes over the interior: off-diagonal relax, diagonal
//   relax, copy back. every interior cell is checked; a relaxed cell then makes 4
//   reads, accumulates and writes, a copied cell reads and writes, and each pass
//   closes with a check past the last row. setup runs through ST_PREP, ST_PREP2.
//   the output side reads one beat at a time from the grid memory read port.
// reset
//   control clears, the load position returns to 0, registers take their
//   reset values; the memories hold whatever they held.
// stall
//   a stalled output holds its beat; no input is accepted until the last output
//   beat is taken.
module poisson_jacobi_grid_solver_unit #(
    parameter int GRID = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // [47:0] cell_value
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata,   // [47:0] result_value, [50:48] row,
                                                       // [53:51] col, [55:54] zero
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [pjg_pkg::IDX_W-1:0]       cfg_index,
    input  logic [pjg_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CELLS = GRID * GRID;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID);
    localparam logic [RW-1:0] LAST_POS  = RW'(GRID - 1);
    localparam logic [RW-1:0] LAST_INT  = RW'(GRID - 2);
    localparam logic [IW-1:0] LAST_CELL = IW'(CELLS - 1);

    typedef enum logic [3:0] {
        ST_LOAD, ST_PREP, ST_PREP2, ST_CHK, ST_RD, ST_ACC, ST_WR,
        ST_CP_RD, ST_CP_WR, ST_EMIT
    } state_t;

    // sweep phases: off-diagonal relax, diagonal relax, copy back
    typedef enum logic [1:0] {
        PH_OFF, PH_DIAG, PH_COPY
    } phase_t;

    state_t                       state_reg, state_next;
    phase_t                       phase_reg, phase_next;
    logic [pjg_pkg::CFG_W-1:0]    iter_cfg_reg;
    logic [pjg_pkg::CFG_W-1:0]    spacing_reg;
    logic [pjg_pkg::CFG_W-1:0]    iter_reg, iter_next;
    logic [IW-1:0]                load_idx_reg, load_idx_next;
    logic [RW-1:0]                r_reg, r_next, c_reg, c_next;
    logic [1:0]                   nb_reg, nb_next;
    logic                         sel_scr_reg, sel_scr_next;
    logic [pjg_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [IW-1:0]                emit_idx_reg, emit_idx_next;
    logic [RW-1:0]                er_reg, er_next, ec_reg, ec_next;
    logic                         issued_reg, issued_next;
    logic                         pend_reg, pend_next;
    logic [RW-1:0]                pend_row_reg, pend_row_next;
    logic [RW-1:0]                pend_col_reg, pend_col_next;
    logic                         pend_last_reg, pend_last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pjg_pkg::VAL_W-1:0]    out_val_reg, out_val_next;
    logic [RW-1:0]                out_row_reg, out_row_next;
    logic [RW-1:0]                out_col_reg, out_col_next;
    logic                         out_last_reg, out_last_next;

    // memory ports
    logic                         g_we, s_we;
    logic [IW-1:0]                g_waddr, s_waddr, raddr;
    logic [pjg_pkg::VAL_W-1:0]    g_wdata, g_q, s_q;
    logic [pjg_pkg::T_W-1:0]      term;

    // neighbor selection and arithmetic
    logic [RW-1:0]                nr, nc;
    logic                         nb_interior;
    logic [IW-1:0]                nb_addr, cur_addr;
    logic [pjg_pkg::VAL_W-1:0]    rd_data;
    logic [pjg_pkg::SUM_W-1:0]    sum;
    logic [48:0]                  quot;
    logic [pjg_pkg::VAL_W-1:0]    relaxed;
    logic                         eligible;
    logic                         in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_cfg_reg <= '0;
            spacing_reg  <= pjg_pkg::CFG_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pjg_pkg::REG_ITERATION_COUNT: iter_cfg_reg <= cfg_data;
                pjg_pkg::REG_GRID_SPACING:    spacing_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    pjg_ram #(.DEPTH(CELLS), .AW(IW), .W(pjg_pkg::VAL_W)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (raddr),
        .rdata (g_q)
    );

    pjg_ram #(.DEPTH(CELLS), .AW(IW), .W(pjg_pkg::VAL_W)) u_scratch (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (relaxed),
        .raddr (raddr),
        .rdata (s_q)
    );

    pjg_src u_src (
        .clk     (clk),
        .prep    (state_reg == ST_PREP),
        .spacing (spacing_reg),
        .row     (pjg_pkg::POS_W'(r_reg)),
        .col     (pjg_pkg::POS_W'(c_reg)),
        .term    (term)
    );

    // neighbor order: up, down, left, right
    always_comb
    begin
        nr = r_reg;
        nc = c_reg;
        case (nb_reg)
            2'd0:    nr = r_reg - RW'(1);
            2'd1:    nr = r_reg + RW'(1);
            2'd2:    nc = c_reg - RW'(1);
            default: nc = c_reg + RW'(1);
        endcase
    end

    assign nb_interior = (nr != '0) && (nr != LAST_POS) && (nc != '0) && (nc != LAST_POS);
    assign nb_addr     = IW'(nr * GRID + nc);
    assign cur_addr    = IW'(r_reg * GRID + c_reg);
    assign rd_data     = sel_scr_reg ? s_q : g_q;
    assign eligible    = (phase_reg == PH_DIAG) ? (r_reg == c_reg) : (r_reg != c_reg);

    // floor divide by four, then clamp to 48 bits
    assign sum  = {acc_reg[pjg_pkg::ACC_W-1], acc_reg} + {7'b0, term};
    assign quot = sum[50:2];
    always_comb
    begin
        if (!quot[48] && quot[47])
        begin
            relaxed = {1'b0, {47{1'b1}}};
        end
        else if (quot[48] && !quot[47])
        begin
            relaxed = {1'b1, 47'b0};
        end
        else
        begin
            relaxed = quot[47:0];
        end
    end

    // memory port steering
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = cur_addr;
        g_wdata = relaxed;
        s_we    = 1'b0;
        s_waddr = cur_addr;
        raddr   = nb_addr;
        case (state_reg)
            ST_LOAD:
            begin
                g_we    = in_acc;
                g_waddr = load_idx_reg;
                g_wdata = s_tdata;
            end
            ST_WR:
            begin
                g_we = (phase_reg == PH_DIAG);
                s_we = (phase_reg == PH_OFF);
            end
            ST_CP_RD: raddr = cur_addr;
            ST_CP_WR:
            begin
                g_we    = 1'b1;
                g_wdata = s_q;
            end
            ST_EMIT:  raddr = emit_idx_reg;
            default:  ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        iter_next      = iter_reg;
        load_idx_next  = load_idx_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        nb_next        = nb_reg;
        sel_scr_next   = sel_scr_reg;
        acc_next       = acc_reg;
        emit_idx_next  = emit_idx_reg;
        er_next        = er_reg;
        ec_next        = ec_reg;
        issued_next    = issued_reg;
        pend_next      = 1'b0;
        pend_row_next  = pend_row_reg;
        pend_col_next  = pend_col_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    load_idx_next = (load_idx_reg == LAST_CELL) ? '0 : load_idx_reg + IW'(1);
                    if (s_tlast)
                    begin
                        load_idx_next = '0;
                        iter_next     = iter_cfg_reg;
                        state_next    = ST_PREP;
                    end
                end
            end
            ST_PREP: state_next = ST_PREP2;
            ST_PREP2:
            begin
                phase_next = PH_OFF;
                r_next     = RW'(1);
                c_next     = RW'(1);
                state_next = (iter_reg == '0) ? ST_EMIT : ST_CHK;
                emit_idx_next = '0;
                er_next       = '0;
                ec_next       = '0;
                issued_next   = 1'b0;
            end
            ST_CHK:
            begin
                if (r_reg == LAST_POS)
                begin
                    r_next = RW'(1);
                    c_next = RW'(1);
                    case (phase_reg)
                        PH_OFF:  phase_next = PH_DIAG;
                        PH_DIAG: phase_next = PH_COPY;
                        default:
                        begin
                            phase_next = PH_OFF;
                            iter_next  = iter_reg - pjg_pkg::CFG_W'(1);
                            if (iter_reg == pjg_pkg::CFG_W'(1))
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
                else if (eligible)
                begin
                    nb_next    = '0;
                    state_next = (phase_reg == PH_COPY) ? ST_CP_RD : ST_RD;
                end
                else if (c_reg == LAST_INT)
                begin
                    c_next = RW'(1);
                    r_next = r_reg + RW'(1);
                end
                else
                begin
                    c_next = c_reg + RW'(1);
                end
            end
            ST_RD:
            begin
                // diagonal cells see the fresh interior values in scratch
                sel_scr_next = (phase_reg == PH_DIAG) && nb_interior;
                acc_next     = (nb_reg == 2'd0) ? '0
                             : acc_reg + pjg_pkg::ACC_W'($signed(rd_data));
                nb_next      = nb_reg + 2'd1;
                if (nb_reg == 2'd3)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + pjg_pkg::ACC_W'($signed(rd_data));
                state_next = ST_WR;
            end
            ST_WR, ST_CP_WR:
            begin
                if (c_reg == LAST_INT)
                begin
                    c_next = RW'(1);
                    r_next = r_reg + RW'(1);
                end
                else
                begin
                    c_next = c_reg + RW'(1);
                end
                state_next = ST_CHK;
            end
            ST_CP_RD: state_next = ST_CP_WR;
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                end
                if (pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = g_q;
                    out_row_next   = pend_row_reg;
                    out_col_next   = pend_col_reg;
                    out_last_next  = pend_last_reg;
                end
                // one read in flight, issued only when the output slot frees
                if (!issued_reg && !pend_reg && (!out_valid_reg || m_tready))
                begin
                    pend_next      = 1'b1;
                    pend_row_next  = er_reg;
                    pend_col_next  = ec_reg;
                    pend_last_next = (emit_idx_reg == LAST_CELL);
                    emit_idx_next  = emit_idx_reg + IW'(1);
                    if (emit_idx_reg == LAST_CELL)
                    begin
                        issued_next = 1'b1;
                    end
                    if (ec_reg == LAST_POS)
                    begin
                        ec_next = '0;
                        er_next = er_reg + RW'(1);
                    end
                    else
                    begin
                        ec_next = ec_reg + RW'(1);
                    end
                end
                if (out_acc && out_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            phase_reg     <= PH_OFF;
            iter_reg      <= '0;
            load_idx_reg  <= '0;
            r_reg         <= RW'(1);
            c_reg         <= RW'(1);
            nb_reg        <= '0;
            sel_scr_reg   <= 1'b0;
            emit_idx_reg  <= '0;
            er_reg        <= '0;
            ec_reg        <= '0;
            issued_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            iter_reg      <= iter_next;
            load_idx_reg  <= load_idx_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            nb_reg        <= nb_next;
            sel_scr_reg   <= sel_scr_next;
            emit_idx_reg  <= emit_idx_next;
            er_reg        <= er_next;
            ec_reg        <= ec_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        pend_row_reg  <= pend_row_next;
        pend_col_reg  <= pend_col_next;
        pend_last_reg <= pend_last_next;
        out_val_reg   <= out_val_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, pjg_pkg::POS_W'(out_col_reg), pjg_pkg::POS_W'(out_row_reg),
                       out_val_reg};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("load and emit active together");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("emit read lands on a full output slot");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_row_reg == LAST_POS && out_col_reg == LAST_POS))
        else $error("last beat not on the final cell");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_row_reg <= LAST_POS && out_col_reg <= LAST_POS))
        else $error("emitted position outside the grid");

    a_wr_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> (state_reg == ST_WR))
        else $error("relax result not written after last neighbor");
`endif

endmodule

[sim/tb_poisson_jacobi_grid_solver_unit.sv]
// testbench for the five-point jacobi poisson grid solver
module tb_poisson_jacobi_grid_solver_unit;

    localparam int GRID   = 4;
    localparam int CELLS  = GRID * GRID;
    localparam int LIMIT  = 400000;
    localparam longint MAX48 = (64'sd1 <<< 47) - 1;
    localparam longint MIN48 = -(64'sd1 <<< 47);

    typedef struct {
        logic [pjg_pkg::VAL_W-1:0] value;
        logic [pjg_pkg::POS_W-1:0] row;
        logic [pjg_pkg::POS_W-1:0] col;
        logic                      last;
    } grid_beat_t;

    // mirror of the solver: grid contents, load position, registers, pending beats
    class grid_scoreboard;
        longint        cells [CELLS];
        int unsigned   load_pos;
        int unsigned   sweeps;
        int unsigned   spacing;
        grid_beat_t    pending [$];
        int            errors;

        function new();
            load_pos = 0;
            sweeps   = 0;
            spacing  = 4096;
            errors   = 0;
            foreach (cells[k]) cells[k] = 0;
        endfunction

        function void write_reg(logic [pjg_pkg::IDX_W-1:0] idx,
                                logic [pjg_pkg::CFG_W-1:0] d);
            if (idx == pjg_pkg::REG_ITERATION_COUNT)
                sweeps = d;
            else if (idx == pjg_pkg::REG_GRID_SPACING)
                spacing = d;
        endfunction

        // -h^2 * f(i*h, j*h) in q.16, never negative
        function longint source(int i, int j);
            longint unsigned hh, h2, s, a, t;
            hh = longint'(spacing) * longint'(spacing);
            h2 = hh >> 8;
            s  = i * i + j * j;
            a  = h2 * s + (64'd10 << 16);
            t  = (h2 * (64'd10 * a)) >> 16;
            return longint'(t);
        endfunction

        function longint relax(longint src [CELLS], int i, int j);
            longint sum, q;
            sum = src[(i-1)*GRID+j] + src[(i+1)*GRID+j] + src[i*GRID+j-1]
                + src[i*GRID+j+1] + source(i, j);
            q = sum >>> 2;   // floor division
            if (q > MAX48) q = MAX48;
            if (q < MIN48) q = MIN48;
            return q;
        endfunction

        function void note_cell(logic [pjg_pkg::VAL_W-1:0] v, bit last);
            longint scratch [CELLS];
            grid_beat_t b;
            cells[load_pos] = longint'($signed(v));
            load_pos = (load_pos + 1) % CELLS;
            if (!last)
                return;
            for (int it = 0; it < sweeps; it++)
            begin
                scratch = cells;
                for (int i = 1; i < GRID - 1; i++)
                    for (int j = 1; j < GRID - 1; j++)
                        if (i != j)
                            scratch[i*GRID+j] = relax(cells, i, j);
                // diagonal uses the freshly updated neighbors
                for (int i = 1; i < GRID - 1; i++)
                    scratch[i*GRID+i] = relax(scratch, i, i);
                cells = scratch;
            end
            for (int k = 0; k < CELLS; k++)
            begin
                b.value = cells[k][pjg_pkg::VAL_W-1:0];
                b.row   = pjg_pkg::POS_W'(k / GRID);
                b.col   = pjg_pkg::POS_W'(k % GRID);
                b.last  = (k == CELLS - 1);
                pending.push_back(b);
            end
            load_pos = 0;
        endfunction

        function void check_beat(logic [55:0] d, logic l);
            grid_beat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat data=%h last=%b", $time, d, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[47:0] !== e.value)
            begin
                $display("%0t: value expected %h actual %h", $time, e.value, d[47:0]);
                errors++;
            end
            if (d[50:48] !== e.row)
            begin
                $display("%0t: row expected %0d actual %0d", $time, e.row, d[50:48]);
                errors++;
            end
            if (d[53:51] !== e.col)
            begin
                $display("%0t: col expected %0d actual %0d", $time, e.col, d[53:51]);
                errors++;
            end
            if (d[55:54] !== 2'b00)
            begin
                $display("%0t: pad expected 0 actual %b", $time, d[55:54]);
                errors++;
            end
            if (l !== e.last)
            begin
                $display("%0t: last expected %b actual %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [47:0]                  s_tdata;    // [47:0] cell_value
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [55:0]                  m_tdata;    // [47:0] result_value, [50:48] row, [53:51] col
    logic                         m_tlast;
    logic                         cfg_we;
    logic [pjg_pkg::IDX_W-1:0]    cfg_index;
    logic [pjg_pkg::CFG_W-1:0]    cfg_data;

    grid_scoreboard grid_sb;
    int             cell_count;
    int             rx_hold;      // receiver hold-off, counted down in the receiver
    int             cycle_count;

    poisson_jacobi_grid_solver_unit #(.GRID(GRID)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 unit period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output beats are checked at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            grid_sb.check_beat(m_tdata, m_tlast);

    // receiver: ready changes at the falling edge, mostly short stalls, a few long
    initial
    begin
        int stall;
        int r;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready = 1'b0;
                rx_hold--;
            end
            else if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    stall = $urandom_range(10, 40);
                else if (r < 25)
                    stall = $urandom_range(1, 3);
                m_tready = (stall == 0);
            end
        end
    end

    function automatic logic [47:0] pick_cell();
        case ($urandom_range(0, 7))
            0: return 48'(MAX48);
            1: return 48'(MIN48);
            2: return 48'(longint'($urandom_range(0, 2000)) - 1000);
            3: return 48'({$urandom, $urandom} >> 20);       // modest positive
            4: return 48'(-({$urandom, $urandom} >> 20));    // modest negative
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send_cell(logic [47:0] v, bit last, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        grid_sb.note_cell(v, last);
        cell_count++;
    endtask

    task automatic send_frame(int n);
        for (int k = 0; k < n; k++)
            send_cell(pick_cell(), k == n - 1, pick_gap());
    endtask

    task automatic send_const_frame(logic [47:0] v);
        for (int k = 0; k < CELLS; k++)
            send_cell(v, k == CELLS - 1, 0);
    endtask

    // let every pending beat drain, then settle before touching registers
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (grid_sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [pjg_pkg::IDX_W-1:0] idx, logic [pjg_pkg::CFG_W-1:0] d);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_we = 1'b0;
        grid_sb.write_reg(idx, d);
    endtask

    initial
    begin
        logic [47:0] directed [CELLS];
        int n;
        grid_sb     = new();
        cell_count  = 0;
        cycle_count = 0;
        rx_hold     = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = pjg_pkg::REG_ITERATION_COUNT;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero sweeps: the loaded grid comes back untouched, field extremes
        directed = '{48'(MAX48), 48'(MIN48), 48'd0, '1, 48'd1, 48'h5555_5555_5555,
                     48'haaaa_aaaa_aaaa, 48'd65536, -48'd65536, 48'd3, -48'd3,
                     48'h0000_ffff_0000, 48'(MAX48), 48'(MIN48), 48'd7, -48'd1};
        for (int k = 0; k < CELLS; k++)
            send_cell(directed[k], k == CELLS - 1, 0);
        wait_drained();

        // sweep count extreme is written, then replaced before any solve
        write_reg(pjg_pkg::REG_ITERATION_COUNT, 16'hffff);
        write_reg(pjg_pkg::REG_ITERATION_COUNT, 16'd1);
        send_const_frame(48'(MAX48));          // positive saturation
        wait_drained();

        write_reg(pjg_pkg::REG_GRID_SPACING, 16'd0);    // zero spacing, no source term
        send_const_frame(48'(MIN48));
        wait_drained();

        write_reg(pjg_pkg::REG_GRID_SPACING, 16'hffff);
        write_reg(pjg_pkg::REG_ITERATION_COUNT, 16'd3);
        write_reg(2'd2, 16'h1234);             // indexes past the registers are ignored
        write_reg(2'd3, 16'hffff);
        send_cell(48'd100, 1'b0, 0);           // early last on the stored grid
        send_cell(-48'd100, 1'b1, 0);
        wait_drained();

        write_reg(pjg_pkg::REG_GRID_SPACING, 16'd1);
        send_frame(CELLS + 4);                 // wraps over the start of the grid
        wait_drained();

        write_reg(pjg_pkg::REG_GRID_SPACING, 16'd4096);
        write_reg(pjg_pkg::REG_ITERATION_COUNT, 16'd2);

        // receiver holds off while the sender keeps offering a second grid
        rx_hold = 300;
        send_frame(CELLS);
        send_frame(CELLS);

        while (cell_count < 350)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_drained();
                write_reg(pjg_pkg::REG_ITERATION_COUNT, 16'($urandom_range(0, 6)));
                case ($urandom_range(0, 4))
                    0: write_reg(pjg_pkg::REG_GRID_SPACING, 16'hffff);
                    1: write_reg(pjg_pkg::REG_GRID_SPACING, 16'd1);
                    default: write_reg(pjg_pkg::REG_GRID_SPACING, 16'($urandom));
                endcase
            end
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, CELLS - 1);
                1: n = $urandom_range(CELLS + 1, CELLS + 8);
                default: n = CELLS;
            endcase
            send_frame(n);
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (grid_sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (grid_sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
design/pjg_pkg.sv
design/pjg_ram.sv
design/pjg_src.sv
design/poisson_jacobi_grid_solver_unit.sv
sim/tb_poisson_jacobi_grid_solver_unit.sv
